>>> rtl/core/pgnt_pkg.sv
// Package for the polar Gaussian noise tracker: sizes, constants, state type.
`timescale 1ns / 1ps
package pgnt_pkg;

   localparam int SENSOR_SLOTS    = 16;
   localparam int AXES_PER_SENSOR = 3;

   localparam int SLOT_W    = $clog2(SENSOR_SLOTS);
   localparam int AXIS_W    = (AXES_PER_SENSOR > 1) ? $clog2(AXES_PER_SENSOR) : 1;
   localparam int CNT_W     = $clog2(AXES_PER_SENSOR + 1);
   localparam int STORE_DEPTH = SENSOR_SLOTS * AXES_PER_SENSOR;
   localparam int ADDR_W    = $clog2(STORE_DEPTH);
   localparam int READ_AXES = (AXES_PER_SENSOR < 3) ? AXES_PER_SENSOR : 3;
   localparam int NOISE_W   = 16;
   localparam int LOG_W     = 46;

   localparam logic [31:0] GAIN_Q32 = 32'd952654231;
   localparam logic [32:0] FULL33   = 33'h0_FFFF_FFFF;
   localparam logic [63:0] LIMIT    = 64'hFFFF_FFFE_0000_0001;

   // Elaboration-time log2 in Q40, same squaring recurrence as the datapath.
   function automatic logic [LOG_W-1:0] log2_q40(input logic [63:0] x);
      logic [63:0]       m;
      logic [127:0]      p;
      logic [LOG_W-1:0]  res;
      int                k;
      k = 63;
      while (k > 0 && x[k] == 1'b0) k--;
      m = (k <= 62) ? (x << (62 - k)) : (x >> 1);
      res = LOG_W'(k) << 40;
      for (int i = 39; i >= 0; i--) begin
         p = {64'd0, m} * {64'd0, m};
         if (|p[127:125]) begin
            m = p[126:63];
            res[i] = 1'b1;
         end else begin
            m = p[125:62];
         end
      end
      return res;
   endfunction

   localparam logic [LOG_W-1:0] LD_Q40 = log2_q40(LIMIT);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_NORM, ST_LOG, ST_L2, ST_DIV, ST_GMUL, ST_WMUL,
      ST_SQRT, ST_FIN, ST_REC, ST_RD, ST_RDCAP, ST_OUT
   } state_type;

endpackage

>>> rtl/core/pgnt_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module pgnt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 48,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/polar_gaussian_noise_tracker_top.sv
// Polar Gaussian noise generator with per-sensor tracking records.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | cmd, sensor_num, track, rand_u, rand_v
//   rsp     | out       | rsp_valid/rsp_ready  | accepted, noise_value, had_values, axes
//
// One transaction at a time. A spare draw goes straight to recording, a read walks the
// stored axes, and a rejected pair stops after squaring. A fresh pair normalizes the sum,
// runs the 40 log squarings on the shared 32x32 multiplier, and then for each value runs
// the bit-serial divide, the gain product and the bit-serial square root.
// Synchronous reset clears the spare, the counts and the handshake state; the store
// needs no clearing since the counts gate every read. While a result waits on
// rsp_ready one new request may be taken; it then holds in its output step.
`timescale 1ns / 1ps
module polar_gaussian_noise_tracker_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [7:0]         req_sensor_num,
   input  logic               req_track,
   input  logic [31:0]        req_rand_u,
   input  logic [31:0]        req_rand_v,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic signed [pgnt_pkg::NOISE_W-1:0] rsp_noise_value,
   output logic               rsp_had_values,
   output logic signed [pgnt_pkg::NOISE_W-1:0] rsp_axis_zero_noise,
   output logic signed [pgnt_pkg::NOISE_W-1:0] rsp_axis_one_noise,
   output logic signed [pgnt_pkg::NOISE_W-1:0] rsp_axis_two_noise
);
   import pgnt_pkg::*;

   state_type state_ff, state_in;
   logic [2:0]   ph_ff, ph_in;
   logic [5:0]   cnt_ff, cnt_in;

   logic         track_ff, track_in;
   logic [7:0]   id_ff, id_in;
   logic [31:0]  ru_ff, ru_in, rv_ff, rv_in;

   logic         pend_ff, pend_in;
   logic [15:0]  spare_ff, spare_in;

   logic [63:0]  su_ff, su_in, sv_ff, sv_in, sum_ff, sum_in;
   logic [63:0]  x_ff, x_in;
   logic [LOG_W-1:0] res_ff, res_in, l2_ff, l2_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  prod_ff;
   logic [63:0]  rem_ff, rem_in;
   logic [31:0]  q_ff, q_in;
   logic [61:0]  g_ff, g_in;
   logic [31:0]  w_ff, w_in;
   logic         big_ff, big_in;
   logic [15:0]  r_ff, r_in;
   logic         sel_ff, sel_in;
   logic [15:0]  valu_ff, valu_in;
   logic         ok_ff, ok_in, had_ff, had_in;
   logic [15:0]  ax_ff [3];
   logic [15:0]  ax_in [3];

   logic         rsp_valid_ff, rsp_valid_in, rsp_acc_ff, rsp_acc_in, rsp_had_ff, rsp_had_in;
   logic [15:0]  rsp_noise_ff, rsp_noise_in;
   logic [15:0]  rsp_ax_ff [3];
   logic [15:0]  rsp_ax_in [3];

   logic [CNT_W-1:0] cnt_arr_ff [SENSOR_SLOTS];
   logic             cnt_wr_en;
   logic [CNT_W-1:0] cnt_wr_val;

   logic [31:0]  mul_a, mul_b;

   // Coordinate magnitudes: |2r - (2^32-1)|.
   logic [32:0]  two_u, two_v, du_p, du_n, dv_p, dv_n;
   logic         nu, nv;
   logic [31:0]  mu, mv;
   assign two_u = {ru_ff, 1'b0};
   assign two_v = {rv_ff, 1'b0};
   assign du_p  = two_u - FULL33;
   assign du_n  = FULL33 - two_u;
   assign dv_p  = two_v - FULL33;
   assign dv_n  = FULL33 - two_v;
   assign nu    = ~ru_ff[31];
   assign nv    = ~rv_ff[31];
   assign mu    = nu ? du_n[31:0] : du_p[31:0];
   assign mv    = nv ? dv_n[31:0] : dv_p[31:0];

   logic [64:0]  sum65;
   assign sum65 = {1'b0, su_ff} + {1'b0, sv_ff};

   logic [64:0]  rem_sh, rem_sub;
   assign rem_sh  = {rem_ff, 1'b0};
   assign rem_sub = rem_sh - {1'b0, sum_ff};

   logic [15:0]  sq_t;
   assign sq_t = r_ff | (16'd1 << cnt_ff[3:0]);

   logic [16:0]  qmag, qneg;
   logic         neg;
   logic [15:0]  val16;
   assign qmag  = big_ff ? 17'd32768 : (({1'b0, r_ff} + 17'd1) >> 1);
   assign qneg  = 17'd0 - qmag;
   assign neg   = sel_ff ? nv : nu;
   assign val16 = neg ? qneg[15:0] : ((qmag > 17'd32767) ? 16'h7FFF : qmag[15:0]);

   logic              id_ok;
   logic [SLOT_W-1:0] slot;
   logic [CNT_W-1:0]  cur_cnt;
   logic [AXIS_W-1:0] axis_wr, axis_sel;
   logic [ADDR_W-1:0] ram_addr;
   logic              ram_we;
   logic [15:0]       ram_rdata;
   assign id_ok    = {1'b0, id_ff} < 9'(SENSOR_SLOTS);
   assign slot     = id_ff[SLOT_W-1:0];
   assign cur_cnt  = cnt_arr_ff[slot];
   assign axis_wr  = (cur_cnt < CNT_W'(AXES_PER_SENSOR)) ? AXIS_W'(cur_cnt)
                                                         : AXIS_W'(AXES_PER_SENSOR - 1);
   assign axis_sel = (state_ff == ST_REC) ? axis_wr : AXIS_W'(cnt_ff);
   assign ram_addr = ADDR_W'(32'(slot) * AXES_PER_SENSOR + 32'(axis_sel));
   assign ram_we   = (state_ff == ST_REC) && track_ff && id_ok;

   pgnt_ram #(.WIDTH(NOISE_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (valu_ff),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;  ph_in = ph_ff;  cnt_in = cnt_ff;
      track_in = track_ff;  id_in = id_ff;
      ru_in = ru_ff;  rv_in = rv_ff;
      pend_in = pend_ff;  spare_in = spare_ff;
      su_in = su_ff;  sv_in = sv_ff;  sum_in = sum_ff;  x_in = x_ff;
      res_in = res_ff;  l2_in = l2_ff;  acc_in = acc_ff;
      rem_in = rem_ff;  q_in = q_ff;  g_in = g_ff;  w_in = w_ff;  big_in = big_ff;
      r_in = r_ff;  sel_in = sel_ff;  valu_in = valu_ff;
      ok_in = ok_ff;  had_in = had_ff;
      for (int j = 0; j < 3; j++) begin
         ax_in[j]     = ax_ff[j];
         rsp_ax_in[j] = rsp_ax_ff[j];
      end
      rsp_valid_in = rsp_valid_ff;  rsp_acc_in = rsp_acc_ff;
      rsp_had_in = rsp_had_ff;  rsp_noise_in = rsp_noise_ff;
      cnt_wr_en = 1'b0;  cnt_wr_val = cur_cnt;
      mul_a = 32'd0;  mul_b = 32'd0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               id_in = req_sensor_num;  track_in = req_track;
               ru_in = req_rand_u;  rv_in = req_rand_v;
               ok_in = 1'b0;  had_in = 1'b0;
               for (int j = 0; j < 3; j++) ax_in[j] = 16'd0;
               ph_in = 3'd0;  cnt_in = 6'd0;
               if (req_cmd) begin
                  state_in = ({1'b0, req_sensor_num} < 9'(SENSOR_SLOTS)) ? ST_RD : ST_OUT;
               end else if (pend_ff) begin
                  valu_in = spare_ff;  pend_in = 1'b0;  state_in = ST_REC;
               end else begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               3'd0: begin mul_a = mu;  mul_b = mu; end
               3'd1: begin su_in = prod_ff;  mul_a = mv;  mul_b = mv; end
               3'd2: sv_in = prod_ff;
               default: begin
                  if (sum65 >= {1'b0, LIMIT}) begin
                     state_in = ST_OUT;
                  end else begin
                     sum_in = sum65[63:0];  x_in = sum65[63:0];
                     res_in = {6'd63, 40'd0};
                     state_in = ST_NORM;
                  end
               end
            endcase
         end
         ST_NORM: begin
            // Shift left until the top bit is set; the mantissa is then the word halved.
            if (!x_ff[63]) begin
               x_in = {x_ff[62:0], 1'b0};
               res_in[45:40] = res_ff[45:40] - 6'd1;
            end else begin
               x_in = {1'b0, x_ff[63:1]};
               cnt_in = 6'd39;  ph_in = 3'd0;  state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               3'd0: begin mul_a = x_ff[31:0];  mul_b = x_ff[31:0]; end
               3'd1: begin
                  acc_in = {64'd0, prod_ff};
                  mul_a = x_ff[31:0];  mul_b = x_ff[63:32];
               end
               3'd2: begin
                  acc_in = acc_ff + {31'd0, prod_ff, 33'd0};
                  mul_a = x_ff[63:32];  mul_b = x_ff[63:32];
               end
               3'd3: acc_in = acc_ff + {prod_ff, 64'd0};
               default: begin
                  if (|acc_ff[127:125]) begin
                     x_in = acc_ff[126:63];
                     res_in[cnt_ff] = 1'b1;
                  end else begin
                     x_in = acc_ff[125:62];
                  end
                  ph_in = 3'd0;
                  if (cnt_ff == 6'd0) state_in = ST_L2;
                  else cnt_in = cnt_ff - 6'd1;
               end
            endcase
         end
         ST_L2: begin
            l2_in = (LD_Q40 > res_ff) ? (LD_Q40 - res_ff) : '0;
            sel_in = 1'b0;  rem_in = su_ff;  q_in = 32'd0;  cnt_in = 6'd31;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, sum_ff}) begin
               rem_in = rem_sub[63:0];  q_in = {q_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh[63:0];  q_in = {q_ff[30:0], 1'b0};
            end
            if (cnt_ff == 6'd0) begin
               ph_in = 3'd0;  state_in = ST_GMUL;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         ST_GMUL: begin
            if (ph_ff == 3'd0) begin
               mul_a = GAIN_Q32;  mul_b = q_ff;  ph_in = 3'd1;
            end else begin
               g_in = prod_ff[61:0];  ph_in = 3'd0;  state_in = ST_WMUL;
            end
         end
         ST_WMUL: begin
            ph_in = ph_ff + 3'd1;
            case (ph_ff)
               3'd0: begin mul_a = g_ff[31:0];  mul_b = l2_ff[31:0]; end
               3'd1: begin
                  acc_in = {64'd0, prod_ff};
                  mul_a = g_ff[31:0];  mul_b = {18'd0, l2_ff[45:32]};
               end
               3'd2: begin
                  acc_in = acc_ff + {32'd0, prod_ff, 32'd0};
                  mul_a = {2'd0, g_ff[61:32]};  mul_b = l2_ff[31:0];
               end
               3'd3: begin
                  acc_in = acc_ff + {32'd0, prod_ff, 32'd0};
                  mul_a = {2'd0, g_ff[61:32]};  mul_b = {18'd0, l2_ff[45:32]};
               end
               3'd4: acc_in = acc_ff + {prod_ff, 64'd0};
               default: begin
                  w_in = acc_ff[103:72];  big_in = |acc_ff[127:104];
                  r_in = 16'd0;  cnt_in = 6'd15;  ph_in = 3'd0;
                  state_in = (|acc_ff[127:104]) ? ST_FIN : ST_SQRT;
               end
            endcase
         end
         ST_SQRT: begin
            if (ph_ff == 3'd0) begin
               mul_a = {16'd0, sq_t};  mul_b = {16'd0, sq_t};  ph_in = 3'd1;
            end else begin
               if (prod_ff <= {32'd0, w_ff}) r_in = sq_t;
               ph_in = 3'd0;
               if (cnt_ff == 6'd0) state_in = ST_FIN;
               else cnt_in = cnt_ff - 6'd1;
            end
         end
         ST_FIN: begin
            if (!sel_ff) begin
               valu_in = val16;  sel_in = 1'b1;
               rem_in = sv_ff;  q_in = 32'd0;  cnt_in = 6'd31;
               state_in = ST_DIV;
            end else begin
               spare_in = val16;  pend_in = 1'b1;  state_in = ST_REC;
            end
         end
         ST_REC: begin
            ok_in = 1'b1;
            if (track_ff && id_ok && cur_cnt < CNT_W'(AXES_PER_SENSOR)) begin
               cnt_wr_en = 1'b1;  cnt_wr_val = cur_cnt + CNT_W'(1);
            end
            state_in = ST_OUT;
         end
         ST_RD: state_in = ST_RDCAP;
         ST_RDCAP: begin
            had_in = (cur_cnt != '0);
            if ({{(32-6){1'b0}}, cnt_ff} < 32'(cur_cnt)) ax_in[cnt_ff[1:0]] = ram_rdata;
            if (cnt_ff == 6'(READ_AXES - 1)) begin
               cnt_wr_en = 1'b1;  cnt_wr_val = '0;  state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + 6'd1;  state_in = ST_RD;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = ok_ff;
               rsp_noise_in = ok_ff ? valu_ff : 16'd0;
               rsp_had_in   = had_ff;
               for (int j = 0; j < 3; j++) rsp_ax_in[j] = ax_ff[j];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;  ph_ff <= 3'd0;  cnt_ff <= 6'd0;
         pend_ff <= 1'b0;  spare_ff <= 16'd0;  rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SENSOR_SLOTS; s++) cnt_arr_ff[s] <= '0;
      end else begin
         state_ff <= state_in;  ph_ff <= ph_in;  cnt_ff <= cnt_in;
         pend_ff <= pend_in;  spare_ff <= spare_in;  rsp_valid_ff <= rsp_valid_in;
         if (cnt_wr_en) cnt_arr_ff[slot] <= cnt_wr_val;
      end
      track_ff <= track_in;  id_ff <= id_in;
      ru_ff <= ru_in;  rv_ff <= rv_in;
      su_ff <= su_in;  sv_ff <= sv_in;  sum_ff <= sum_in;  x_ff <= x_in;
      res_ff <= res_in;  l2_ff <= l2_in;  acc_ff <= acc_in;
      prod_ff <= {32'd0, mul_a} * {32'd0, mul_b};
      rem_ff <= rem_in;  q_ff <= q_in;  g_ff <= g_in;  w_ff <= w_in;  big_ff <= big_in;
      r_ff <= r_in;  sel_ff <= sel_in;  valu_ff <= valu_in;
      ok_ff <= ok_in;  had_ff <= had_in;
      for (int j = 0; j < 3; j++) begin
         ax_ff[j]     <= ax_in[j];
         rsp_ax_ff[j] <= rsp_ax_in[j];
      end
      rsp_acc_ff <= rsp_acc_in;  rsp_had_ff <= rsp_had_in;  rsp_noise_ff <= rsp_noise_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_noise_value     = rsp_noise_ff;
   assign rsp_had_values      = rsp_had_ff;
   assign rsp_axis_zero_noise = rsp_ax_ff[0];
   assign rsp_axis_one_noise  = rsp_ax_ff[1];
   assign rsp_axis_two_noise  = rsp_ax_ff[2];
endmodule
